/* rtl/core/pasm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the polynomial add / subtract / multiply engine
// no dependencies

package pasm_pkg;

  localparam int MaxTermsDef = 16;
  localparam int OpW         = 3;
  localparam int IdxW        = 4;
  localparam int ValW        = 32;
  localparam int ResIdxW     = 5;
  localparam int FifoDepth   = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_SUM    = 3'd2,
    OP_DIFF   = 3'd3,
    OP_PROD   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADDSUB,
    BK_MUL_ACC,
    BK_MUL_FLUSH,
    BK_MUL_EMIT
  } back_state_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] value;
  } cmd_t;

endpackage

/* rtl/core/pasm_if.sv */
`timescale 1ns / 1ps
// valid / ready channel interfaces for the input words and the result words
// depends on pasm_pkg

interface pasm_in_if import pasm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         operation;
  logic [IdxW-1:0]        coeff_index;
  logic signed [ValW-1:0] coeff_value;

  modport source (output valid, operation, coeff_index, coeff_value, input ready);
  modport sink   (input valid, operation, coeff_index, coeff_value, output ready);
endinterface

interface pasm_out_if import pasm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ResIdxW-1:0]     result_index;
  logic signed [ValW-1:0] result_value;
  logic                   last_term;

  modport source (output valid, result_index, result_value, last_term, input ready);
  modport sink   (input valid, result_index, result_value, last_term, output ready);
endinterface

/* rtl/core/pasm_front.sv */
`timescale 1ns / 1ps
// front end: accepts input words, drops unused codes and out-of-range loads,
// and queues the rest for the back end; depends on pasm_pkg, pasm_if

module pasm_front import pasm_pkg::*; #(
  parameter int MAX_TERMS = MaxTermsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pasm_in_if.sink      in_i,
  output cmd_t         cmd_o,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i
);

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  cmd_t            fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  op_e  op;
  logic keep;
  logic push;
  logic pop;

  always_comb begin
    op = op_e'(in_i.operation);
    unique case (op) inside
      OP_LOAD_A, OP_LOAD_B: keep = ({28'd0, in_i.coeff_index} < 32'(MAX_TERMS));
      OP_SUM, OP_DIFF, OP_PROD: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_i.ready  = (cnt_q != CntW'(FifoDepth));
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{op: op, idx: in_i.coeff_index, value: in_i.coeff_value};
    end
  end

endmodule

/* rtl/core/pasm_back.sv */
`timescale 1ns / 1ps
// back end: coefficient stores, add / subtract walk and multiply-accumulate
// sequencer with a registered output word; depends on pasm_pkg, pasm_if

module pasm_back import pasm_pkg::*; #(
  parameter int MAX_TERMS = MaxTermsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  pasm_out_if.source   out_o
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int KW = $clog2(2 * MAX_TERMS - 1);
  localparam logic [IW-1:0] ILast    = IW'(MAX_TERMS - 1);
  localparam logic [KW-1:0] KLastAdd = KW'(MAX_TERMS - 1);
  localparam logic [KW-1:0] KLastMul = KW'(2 * MAX_TERMS - 2);
  localparam logic [KW-1:0] KTerms   = KW'(MAX_TERMS);

  logic [ValW-1:0] a_q [MAX_TERMS];
  logic [ValW-1:0] b_q [MAX_TERMS];

  back_state_e state_q, state_d;
  logic [KW-1:0]   k_q, k_d;
  logic [IW-1:0]   i_q, i_d;
  logic            sub_q, sub_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [ValW-1:0] prod_q, prod_d;
  logic            prod_vld_q, prod_vld_d;

  logic               out_vld_q, out_vld_d;
  logic [ResIdxW-1:0] out_idx_q, out_idx_d;
  logic [ValW-1:0]    out_val_q, out_val_d;
  logic               out_last_q, out_last_d;
  logic               out_ld;
  logic               out_free;

  logic            wr_a, wr_b;
  logic [IW-1:0]   rd_a_idx, rd_b_idx;
  logic [KW-1:0]   b_off;
  logic            term_ok;
  logic [ValW-1:0] a_rd, b_rd;

  // operand selection: same index for add / subtract, i and k-i for the product
  always_comb begin
    b_off    = k_q - KW'(i_q);
    term_ok  = (k_q >= KW'(i_q)) && (b_off < KTerms);
    rd_a_idx = (state_q == BK_ADDSUB) ? k_q[IW-1:0] : i_q;
    rd_b_idx = (state_q == BK_ADDSUB) ? k_q[IW-1:0] : b_off[IW-1:0];
    a_rd     = a_q[rd_a_idx];
    b_rd     = b_q[rd_b_idx];
  end

  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    i_d         = i_q;
    sub_d       = sub_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    prod_vld_d  = 1'b0;
    cmd_ready_o = 1'b0;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    out_ld      = 1'b0;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          unique case (cmd_i.op) inside
            OP_LOAD_A: wr_a = 1'b1;
            OP_LOAD_B: wr_b = 1'b1;
            OP_SUM, OP_DIFF: begin
              sub_d   = (cmd_i.op == OP_DIFF);
              k_d     = '0;
              state_d = BK_ADDSUB;
            end
            OP_PROD: begin
              k_d     = '0;
              i_d     = '0;
              acc_d   = '0;
              state_d = BK_MUL_ACC;
            end
            default: ;
          endcase
        end
      end
      BK_ADDSUB: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_idx_d  = ResIdxW'(k_q);
          out_val_d  = sub_q ? (a_rd - b_rd) : (a_rd + b_rd);
          out_last_d = (k_q == KLastAdd);
          if (k_q == KLastAdd) begin
            state_d = BK_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      BK_MUL_ACC: begin
        prod_d     = term_ok ? (a_rd * b_rd) : '0;
        prod_vld_d = 1'b1;
        if (prod_vld_q) begin
          acc_d = acc_q + prod_q;
        end
        if (i_q == ILast) begin
          state_d = BK_MUL_FLUSH;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      BK_MUL_FLUSH: begin
        // last product of this term
        acc_d   = acc_q + prod_q;
        state_d = BK_MUL_EMIT;
      end
      BK_MUL_EMIT: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_idx_d  = ResIdxW'(k_q);
          out_val_d  = acc_q;
          out_last_d = (k_q == KLastMul);
          acc_d      = '0;
          i_d        = '0;
          if (k_q == KLastMul) begin
            state_d = BK_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = BK_MUL_ACC;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    if (out_ld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      k_q        <= '0;
      i_q        <= '0;
      sub_q      <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      i_q        <= i_d;
      sub_q      <= sub_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  // coefficient stores, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < MAX_TERMS; n++) begin
        a_q[n] <= '0;
        b_q[n] <= '0;
      end
    end else begin
      if (wr_a) begin
        a_q[cmd_i.idx[IW-1:0]] <= cmd_i.value;
      end
      if (wr_b) begin
        b_q[cmd_i.idx[IW-1:0]] <= cmd_i.value;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_index = out_idx_q;
  assign out_o.result_value = out_val_q;
  assign out_o.last_term    = out_last_q;

endmodule

/* rtl/core/polynomial_add_sub_multiply.sv */
`timescale 1ns / 1ps
// load words: queued on acceptance, written to the store once the back end is idle
// add / subtract: MAX_TERMS result words, one per cycle unless the output stalls
// multiply: 2*MAX_TERMS-1 words, each built in turn by the single multiply-accumulate
// a two-word queue lets new words in while the back end is busy
// reset: stores cleared to zero, queue empty, output word invalid

module polynomial_add_sub_multiply import pasm_pkg::*; #(
  parameter int MAX_TERMS = MaxTermsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pasm_in_if.sink      in_i,
  pasm_out_if.source   out_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  pasm_front #(
    .MAX_TERMS (MAX_TERMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  pasm_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

/* rtl/core/pasm_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the result channel of the engine, bound to the top level
// depends on pasm_pkg and polynomial_add_sub_multiply

module pasm_checker import pasm_pkg::*; #(
  parameter int MAX_TERMS = MaxTermsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [ResIdxW-1:0]     out_index_i,
  input logic signed [ValW-1:0] out_value_i,
  input logic                   out_last_i
);

  localparam logic [ResIdxW-1:0] LastAdd = ResIdxW'(MAX_TERMS - 1);
  localparam logic [ResIdxW-1:0] LastMul = ResIdxW'(2 * MAX_TERMS - 2);

  // a word not taken stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word withdrawn before taken");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_index_i) && $stable(out_value_i)
      && $stable(out_last_i))
    else $error("result word changed while stalled");

  // a run ends only on the top power of a sum or of a product
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> (out_index_i == LastAdd) || (out_index_i == LastMul))
    else $error("last mark on wrong power");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result word offered during reset");

endmodule

bind polynomial_add_sub_multiply pasm_checker #(
  .MAX_TERMS (MAX_TERMS)
) u_pasm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.result_index),
  .out_value_i (out_o.result_value),
  .out_last_i  (out_o.last_term)
);
